// ===== hdl/jmsp_pkg.sv =====
// shared types, constants and marker classes for the jpeg marker stream probe
package jmsp_pkg;

   localparam int COUNT_BITS    = 20;
   localparam int SEARCH_WINDOW = 100;
   localparam int TEXT_LEN      = 28;
   localparam int POS_BITS      = 21;
   localparam int START_BITS    = $clog2(SEARCH_WINDOW + 1);
   localparam int SCORE_BITS    = 7;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SCORE_BITS-1:0] SCORE_RESET = 7'd50;

   localparam logic [7:0] BYTE_FF = 8'hFF;

   // CR LF "Content-Type: image/jpeg" CR LF
   localparam logic [7:0] CT_TEXT [TEXT_LEN] = '{
      8'h0D, 8'h0A, 8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h54, 8'h79, 8'h70, 8'h65, 8'h3A, 8'h20, 8'h69, 8'h6D, 8'h61, 8'h67,
      8'h65, 8'h2F, 8'h6A, 8'h70, 8'h65, 8'h67, 8'h0D, 8'h0A
   };

   typedef enum logic [2:0] {
      MK_NONE,
      MK_SOI,
      MK_SOF,
      MK_SOS,
      MK_EOI,
      MK_RESERVED
   } marker_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] probe_score;
      logic [COUNT_BITS-1:0] frame_total;
      logic [COUNT_BITS-1:0] invalid_total;
      logic                  header_text_found;
   } rsp_type;

   typedef struct packed {
      marker_class_type marker;
      logic             last_byte;
      logic             text_ok;
   } item_type;

endpackage

// ===== hdl/jpeg_marker_stream_probe.sv =====
// top level of the jpeg marker stream probe
// a last-byte transaction passes the queue and then the result register
// throughput: one byte per cycle while req_stall is low; the front end, the two-entry queue and the
// result register let each side stall without holding the other
// reset: synchronous, active high; clears sequence state, counters and queue,
// and sets the extension score register ext_ff to 50
module jpeg_marker_stream_probe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  jmsp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output jmsp_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [jmsp_pkg::SCORE_BITS-1:0] csr_write_data
);
   import jmsp_pkg::*;

   logic     push, pop, full, head_valid;
   item_type push_item, head_item;

   jmsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_item  (push_item)
   );

   jmsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   jmsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

// ===== hdl/jmsp_front.sv =====
// front end: byte position, marker detection and classification, header text search
module jmsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jmsp_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output jmsp_pkg::item_type push_item
);
   import jmsp_pkg::*;

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [7:0]            prev_ff, prev_in;
   logic [7:0]            win_ff [TEXT_LEN];
   logic                  seen_ff, seen_in;
   logic [START_BITS-1:0] start_ff, start_in;

   logic             accept;
   logic             is_marker;
   logic             text_hit;
   logic             in_range;
   marker_class_type mclass;
   logic [7:0]       b;

   assign b         = req_data.data_byte;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;
   assign is_marker = (pos_ff != '0) && (prev_ff == BYTE_FF);

   always_comb begin
      mclass = MK_NONE;
      if (is_marker) begin
         priority if (b == 8'hD8) begin
            mclass = MK_SOI;
         end else if ((b >= 8'hC0 && b <= 8'hC3) || (b >= 8'hC5 && b <= 8'hC7)
                      || b == 8'hF7) begin
            mclass = MK_SOF;
         end else if (b == 8'hDA) begin
            mclass = MK_SOS;
         end else if (b == 8'hD9) begin
            mclass = MK_EOI;
         end else if ((b >= 8'h02 && b <= 8'hBF) || b == 8'hC8) begin
            mclass = MK_RESERVED;
         end else begin
            mclass = MK_NONE;
         end
      end
   end

   always_comb begin
      text_hit = (b == CT_TEXT[TEXT_LEN-1]);
      for (int i = 0; i < TEXT_LEN - 1; i++) begin
         if (win_ff[i+1] != CT_TEXT[i]) text_hit = 1'b0;
      end
   end

   assign in_range = (pos_ff >= POS_BITS'(TEXT_LEN - 1)) &&
                     (pos_ff < POS_BITS'(SEARCH_WINDOW + TEXT_LEN - 1));

   always_comb begin
      push_item.marker    = mclass;
      push_item.last_byte = req_data.last_byte;
      // a match on the current byte can never have two bytes after it
      push_item.text_ok   = seen_ff &&
                            (POS_BITS'(start_ff) + POS_BITS'(TEXT_LEN + 1) <= pos_ff);
   end

   always_comb begin
      pos_in   = pos_ff;
      prev_in  = prev_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            pos_in   = '0;
            prev_in  = '0;
            seen_in  = 1'b0;
            start_in = '0;
         end else begin
            prev_in = b;
            if (pos_ff != '1) pos_in = pos_ff + POS_BITS'(1);
            if (!seen_ff && in_range && text_hit) begin
               seen_in  = 1'b1;
               start_in = START_BITS'(pos_ff - POS_BITS'(TEXT_LEN - 1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         prev_ff  <= '0;
         seen_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < TEXT_LEN - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[TEXT_LEN-1] <= b;
      end
   end

endmodule

// ===== hdl/jmsp_queue.sv =====
// short queue of classified transactions between front and back end
module jmsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jmsp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output jmsp_pkg::item_type head_item
);
   import jmsp_pkg::*;

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in;
   logic [QPTR_BITS-1:0] rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_BITS'(1);
      if (pop)  rd_in = (rd_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_BITS'(1);
      if (push && !pop) cnt_in = cnt_ff + QCNT_BITS'(1);
      else if (pop && !push) cnt_in = cnt_ff - QCNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_item;
   end

endmodule

// ===== hdl/jmsp_back.sv =====
// back end: marker sequence tracking, saturating counters, score and result register
module jmsp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [jmsp_pkg::SCORE_BITS-1:0] csr_write_data,
   input  logic                            head_valid,
   input  jmsp_pkg::item_type              head_item,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output jmsp_pkg::rsp_type               rsp_data
);
   import jmsp_pkg::*;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_SOI,
      PH_SOF,
      PH_SOS,
      PH_EOI
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] frames_ff, frames_in;
   logic [COUNT_BITS-1:0] inv_ff, inv_in;
   logic [SCORE_BITS-1:0] ext_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  bump_frame, bump_inv;
   logic [COUNT_BITS+1:0] inv_scaled;
   logic [SCORE_BITS-1:0] score;
   phase_type             phase_step;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop = head_valid && (!head_item.last_byte || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_step = phase_ff;
      bump_frame = 1'b0;
      bump_inv   = 1'b0;
      unique case (head_item.marker)
         MK_SOI: phase_step = PH_SOI;
         MK_SOF: begin
            if (phase_ff == PH_SOI) phase_step = PH_SOF;
            else bump_inv = 1'b1;
         end
         MK_SOS: begin
            if (phase_ff == PH_SOF) phase_step = PH_SOS;
            else bump_inv = 1'b1;
         end
         MK_EOI: begin
            if (phase_ff == PH_SOS) begin
               phase_step = PH_EOI;
               bump_frame = 1'b1;
            end else begin
               bump_inv = 1'b1;
            end
         end
         MK_RESERVED: bump_inv = 1'b1;
         default: ;
      endcase
      frames_in = frames_ff;
      inv_in    = inv_ff;
      phase_in  = phase_step;
      if (bump_frame && frames_ff != '1) frames_in = frames_ff + COUNT_BITS'(1);
      if (bump_inv && inv_ff != '1) inv_in = inv_ff + COUNT_BITS'(1);
   end

   assign inv_scaled = {inv_in, 2'b00} + (COUNT_BITS+2)'(1);

   always_comb begin
      score = '0;
      if (inv_scaled < (COUNT_BITS+2)'(frames_in)) begin
         if (head_item.text_ok) score = ext_ff;
         else if (inv_in == '0 && frames_in > COUNT_BITS'(2)) score = ext_ff >> 1;
         else score = ext_ff >> 2;
      end else if (inv_in == '0 && frames_in != '0) begin
         score = ext_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         frames_ff    <= '0;
         inv_ff       <= '0;
         ext_ff       <= SCORE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) ext_ff <= csr_write_data;
         if (pop) begin
            if (head_item.last_byte) begin
               phase_ff  <= PH_NONE;
               frames_ff <= '0;
               inv_ff    <= '0;
            end else begin
               phase_ff  <= phase_in;
               frames_ff <= frames_in;
               inv_ff    <= inv_in;
            end
         end
         if (pop && head_item.last_byte) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.last_byte) begin
         rsp_ff.probe_score       <= score;
         rsp_ff.frame_total       <= frames_in;
         rsp_ff.invalid_total     <= inv_in;
         rsp_ff.header_text_found <= head_item.text_ok;
      end
   end

endmodule
